>>> src/grid_dijkstra_distance_field_unit_macros.svh
// Assertion macros used by the checker file of the distance field unit.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef GRID_DIJKSTRA_DISTANCE_FIELD_UNIT_MACROS_SVH
`define GRID_DIJKSTRA_DISTANCE_FIELD_UNIT_MACROS_SVH
// same-cycle implication
`define GDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdf assertion failed");
// next-cycle implication
`define GDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdf assertion failed");
`endif

>>> src/gdf_pkg.sv
// Shared types, constants and step tables of the grid distance field unit.
// No dependencies.
`default_nettype none
package gdf_pkg;
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;
    localparam int DIST_W   = 17;
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 10;
    localparam int CLS_W    = 3;
    localparam int CFG_W    = 6;
    localparam int CFG_RST  = 32;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CLS_W-1:0] CLS_ROAD  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_WATER = 3'd2;
    localparam logic [CLS_W-1:0] CLS_GOAL  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_CHECK = 3'd4;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [6:0] COST_ORTHO = 7'd10;
    localparam logic [6:0] COST_DIAG  = 7'd14;
    localparam logic [6:0] COST_WATER = 7'd50;

    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  cls;
    } t_cmd;

    typedef struct packed {
        logic              ready;
        logic              done;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              done_res;
    } t_stat;

    function automatic logic signed [1:0] step_dx(input logic [2:0] dir);
        logic signed [1:0] v;
        unique case (dir)
            3'd0, 3'd4, 3'd5: v = -2'sd1;
            3'd1, 3'd6, 3'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] dir);
        logic signed [1:0] v;
        unique case (dir)
            3'd2, 3'd4, 3'd6: v = -2'sd1;
            3'd3, 3'd5, 3'd7: v = 2'sd1;
            default:          v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic enterable(input logic [CLS_W-1:0] c);
        return (c == CLS_ROAD) || (c == CLS_WATER) || (c == CLS_GOAL) || (c == CLS_CHECK);
    endfunction
endpackage
`default_nettype wire

>>> src/grid_dijkstra_distance_field_unit.sv
// In a compute item each step of the search scans the distance memory for
// the least frontier entry. After reset a clearing pass over all
// MAX_WIDTH*MAX_HEIGHT cells runs before the first item is taken;
// configuration resets to a 32 by 32 grid.
// One item at a time; depends on gdf_pkg and gdf_engine.
`default_nettype none
module grid_dijkstra_distance_field_unit #(
    parameter int MAX_WIDTH  = gdf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gdf_pkg::MAX_HEIGHT_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [gdf_pkg::OP_W-1:0]      i_opcode,
    input  wire [gdf_pkg::ADDR_W-1:0]    i_cell_addr,
    input  wire [gdf_pkg::CLS_W-1:0]     i_cell_class,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [gdf_pkg::DIST_W-1:0]   o_distance,
    output logic                         o_reachable,
    output logic                         o_done_res,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [0:0]                    i_cfg_index,
    input  wire [gdf_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [gdf_pkg::CFG_W-1:0] r_cfg_width;
    logic [gdf_pkg::CFG_W-1:0] r_cfg_height;
    logic                      r_busy;
    logic                      r_out_valid;
    logic [gdf_pkg::DIST_W-1:0] r_distance;
    logic                      r_reachable;
    logic                      r_done_res;
    logic [WW-1:0]             used_w;
    logic [HW-1:0]             used_h;
    logic                      accept;
    gdf_pkg::t_cmd             cmd;
    gdf_pkg::t_stat            stat;

    always_comb begin
        priority if (r_cfg_width == '0) used_w = WW'(1);
        else if (32'(r_cfg_width) > MAX_WIDTH) used_w = WW'(MAX_WIDTH);
        else used_w = WW'(r_cfg_width);
        priority if (r_cfg_height == '0) used_h = HW'(1);
        else if (32'(r_cfg_height) > MAX_HEIGHT) used_h = HW'(MAX_HEIGHT);
        else used_h = HW'(r_cfg_height);
    end

    assign o_stall     = r_busy || !stat.ready || (r_out_valid && i_stall);
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cmd.valid   = accept;
    assign cmd.op      = i_opcode;
    assign cmd.addr    = i_cell_addr;
    assign cmd.cls     = i_cell_class;

    gdf_engine #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_w    (used_w),
        .i_h    (used_h),
        .o_stat (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= gdf_pkg::CFG_W'(gdf_pkg::CFG_RST);
            r_cfg_height <= gdf_pkg::CFG_W'(gdf_pkg::CFG_RST);
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gdf_pkg::REG_WIDTH:  r_cfg_width  <= i_cfg_data;
                    gdf_pkg::REG_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end
            // hold the result until the transfer completes
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end
            if (stat.done) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                r_distance  <= stat.distance;
                r_reachable <= stat.reachable;
                r_done_res  <= stat.done_res;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_distance  = r_distance;
    assign o_reachable = r_reachable;
    assign o_done_res  = r_done_res;
endmodule
`default_nettype wire

>>> src/gdf_engine.sv
// Cell stores and the sequencer that loads, reads and relaxes the distance field.
// Depends on gdf_pkg.
`default_nettype none
module gdf_engine #(
    parameter int MAX_WIDTH  = gdf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gdf_pkg::MAX_HEIGHT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  gdf_pkg::t_cmd                     i_cmd,
    input  wire [$clog2(MAX_WIDTH+1)-1:0]     i_w,
    input  wire [$clog2(MAX_HEIGHT+1)-1:0]    i_h,
    output gdf_pkg::t_stat                    o_stat
);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = WW + HW;
    localparam int DW    = gdf_pkg::DIST_W;
    localparam int MW    = DW + 2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_INIT_RD, S_INIT_WR, S_SCAN_START, S_SCAN, S_POP, S_NB, S_RELAX
    } t_state;

    t_state r_state;
    logic [gdf_pkg::CLS_W-1:0] r_cls_mem [CELLS];
    logic [MW-1:0]             r_dist_mem [CELLS];
    logic [gdf_pkg::CLS_W-1:0] r_cls_rd;
    logic [MW-1:0]             r_dist_rd;

    logic [AW-1:0] r_si;
    logic [WW-1:0] r_sx;
    logic [HW-1:0] r_sy;
    logic          r_issue_done;
    logic          r_pv;
    logic [AW-1:0] r_pi;
    logic [WW-1:0] r_px;
    logic [HW-1:0] r_py;
    logic          r_found;
    logic [AW-1:0] r_best;
    logic [WW-1:0] r_bx;
    logic [HW-1:0] r_by;
    logic [DW-1:0] r_bestd;
    logic [NW-1:0] r_count;
    logic [2:0]    r_dir;
    logic [AW-1:0] r_ni;
    logic          r_done;
    logic [DW-1:0] r_res_dist;
    logic          r_res_reach;
    logic          r_res_done;

    logic [NW-1:0] n_cells;
    logic          last_cell;
    logic signed [WW:0] nx;
    logic signed [HW:0] ny;
    logic          inb;
    logic [PW-1:0] lin;
    logic [AW-1:0] ni;
    logic [DW+1:0] sum;
    logic [DW-1:0] nd;
    logic          upd;
    logic          cls_we;
    logic [AW-1:0] cls_raddr;
    logic          dist_we;
    logic [AW-1:0] dist_waddr;
    logic [MW-1:0] dist_wdata;
    logic [AW-1:0] dist_raddr;
    logic          rd_frontier;
    logic          rd_reach;
    logic [DW-1:0] rd_dist;

    assign n_cells     = NW'(PW'(i_w) * PW'(i_h));
    assign last_cell   = (NW'(r_si) == n_cells - NW'(1));
    assign rd_frontier = r_dist_rd[DW+1];
    assign rd_reach    = r_dist_rd[DW];
    assign rd_dist     = r_dist_rd[DW-1:0];

    always_comb begin
        nx  = $signed({1'b0, r_bx}) + (WW+1)'(gdf_pkg::step_dx(r_dir));
        ny  = $signed({1'b0, r_by}) + (HW+1)'(gdf_pkg::step_dy(r_dir));
        inb = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, i_w}))
              && (ny < $signed({1'b0, i_h}));
        lin = PW'(ny[HW-1:0]) * PW'(i_w) + PW'(nx[WW-1:0]);
        ni  = AW'(lin);
        sum = (DW+2)'(r_bestd)
              + (DW+2)'((r_dir[2]) ? gdf_pkg::COST_DIAG : gdf_pkg::COST_ORTHO)
              + (DW+2)'((r_cls_rd == gdf_pkg::CLS_WATER) ? gdf_pkg::COST_WATER : 7'd0);
        nd  = (sum > (DW+2)'(gdf_pkg::DIST_MAX)) ? gdf_pkg::DIST_MAX : DW'(sum);
        upd = gdf_pkg::enterable(r_cls_rd) && (!rd_reach || (nd < rd_dist));
    end

    always_comb begin
        cls_we     = (r_state == S_IDLE) && i_cmd.valid && (i_cmd.op == gdf_pkg::OP_WRITE)
                     && (32'(i_cmd.addr) < CELLS);
        cls_raddr  = (r_state == S_NB) ? ni : r_si;
        dist_raddr = r_si;
        dist_we    = 1'b0;
        dist_waddr = r_si;
        dist_wdata = '0;
        unique case (r_state)
            S_IDLE:    dist_raddr = AW'(i_cmd.addr);
            S_NB:      dist_raddr = ni;
            S_CLR:     dist_we = 1'b1;
            S_INIT_WR: begin
                dist_we    = 1'b1;
                dist_wdata = {{2{r_cls_rd == gdf_pkg::CLS_GOAL}}, DW'(0)};
            end
            S_POP: begin
                dist_we    = 1'b1;
                dist_waddr = r_best;
                dist_wdata = {2'b01, r_bestd};
            end
            S_RELAX: begin
                dist_we    = upd;
                dist_waddr = r_ni;
                dist_wdata = {2'b11, nd};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cls_we) begin
            r_cls_mem[AW'(i_cmd.addr)] <= i_cmd.cls;
        end
        r_cls_rd <= r_cls_mem[cls_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_waddr] <= dist_wdata;
        end
        r_dist_rd <= r_dist_mem[dist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_si    <= '0;
            r_done  <= 1'b0;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_si <= r_si + AW'(1);
                    if (r_si == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_res_dist  <= '0;
                        r_res_reach <= 1'b0;
                        r_res_done  <= 1'b0;
                        priority if (i_cmd.op == gdf_pkg::OP_WRITE) begin
                            r_res_done <= 1'b1;
                            r_done     <= 1'b1;
                        end else if (i_cmd.op == gdf_pkg::OP_COMPUTE) begin
                            r_si    <= '0;
                            r_count <= '0;
                            r_state <= S_INIT_RD;
                        end else if (i_cmd.op == gdf_pkg::OP_READ
                                     && 32'(i_cmd.addr) < 32'(n_cells)) begin
                            r_state <= S_RD;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_res_dist  <= rd_reach ? rd_dist : '0;
                    r_res_reach <= rd_reach;
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_INIT_RD: r_state <= S_INIT_WR;
                S_INIT_WR: begin
                    r_count <= r_count + NW'(r_cls_rd == gdf_pkg::CLS_GOAL);
                    r_si    <= r_si + AW'(1);
                    r_state <= last_cell ? S_SCAN_START : S_INIT_RD;
                end
                S_SCAN_START: begin
                    if (r_count == '0) begin
                        r_res_done <= 1'b1;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_si         <= '0;
                        r_sx         <= '0;
                        r_sy         <= '0;
                        r_found      <= 1'b0;
                        r_issue_done <= 1'b0;
                        r_pv         <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle, judge the word read the cycle before
                    r_pv <= !r_issue_done;
                    r_pi <= r_si;
                    r_px <= r_sx;
                    r_py <= r_sy;
                    if (!r_issue_done) begin
                        r_si <= r_si + AW'(1);
                        if (r_sx == i_w - WW'(1)) begin
                            r_sx <= '0;
                            r_sy <= r_sy + HW'(1);
                        end else begin
                            r_sx <= r_sx + WW'(1);
                        end
                        r_issue_done <= last_cell;
                    end
                    if (r_pv && rd_frontier && (!r_found || rd_dist < r_bestd)) begin
                        r_found <= 1'b1;
                        r_best  <= r_pi;
                        r_bx    <= r_px;
                        r_by    <= r_py;
                        r_bestd <= rd_dist;
                    end
                    if (r_issue_done && !r_pv) begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_count <= r_count - NW'(1);
                    r_dir   <= '0;
                    r_state <= S_NB;
                end
                S_NB: begin
                    r_ni <= ni;
                    if (inb) begin
                        r_state <= S_RELAX;
                    end else begin
                        r_dir   <= r_dir + 3'd1;
                        r_state <= (r_dir == 3'd7) ? S_SCAN_START : S_NB;
                    end
                end
                S_RELAX: begin
                    if (upd && !rd_frontier) begin
                        r_count <= r_count + NW'(1);
                    end
                    r_dir   <= r_dir + 3'd1;
                    r_state <= (r_dir == 3'd7) ? S_SCAN_START : S_NB;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.ready     = (r_state == S_IDLE);
    assign o_stat.done      = r_done;
    assign o_stat.distance  = r_res_dist;
    assign o_stat.reachable = r_res_reach;
    assign o_stat.done_res  = r_res_done;
endmodule
`default_nettype wire

>>> src/gdf_checker.sv
// Port-level checks of the distance field unit, bound to the top level.
// Depends on grid_dijkstra_distance_field_unit_macros.svh and gdf_pkg.
`default_nettype none
`include "grid_dijkstra_distance_field_unit_macros.svh"
module gdf_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_valid,
    input wire                        o_stall,
    input wire                        o_valid,
    input wire                        i_stall,
    input wire [gdf_pkg::DIST_W-1:0]  o_distance,
    input wire                        o_reachable,
    input wire                        o_done_res
);
    // a held result blocks new work
    `GDF_ASSERT_IMPLY(a_hold_blocks, i_clk, i_rst_n, o_valid && i_stall, o_stall)
    // one item in flight at a time
    `GDF_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `GDF_ASSERT_IMPLY(a_unreach_zero, i_clk, i_rst_n, o_valid && !o_reachable,
        o_distance == '0)
    `GDF_ASSERT_IMPLY(a_reach_read, i_clk, i_rst_n, o_valid && o_reachable, !o_done_res)
endmodule

bind grid_dijkstra_distance_field_unit gdf_checker u_gdf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_distance (o_distance),
    .o_reachable(o_reachable),
    .o_done_res (o_done_res)
);
`default_nettype wire

>>> tb/tb_grid_dijkstra_distance_field_unit.sv
// Self-checking bench for grid_dijkstra_distance_field_unit: a directed table, then random maps.
// Holds its own distance field solver for prediction; depends on gdf_pkg and the RTL.
module tb_grid_dijkstra_distance_field_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [gdf_pkg::OP_W-1:0]  OP_NONE     = 2'd3;
    localparam logic [gdf_pkg::CLS_W-1:0] CLS_BLOCKED = 3'd0;
    localparam logic [gdf_pkg::CLS_W-1:0] CLS_RSVD5   = 3'd5;
    localparam logic [gdf_pkg::CLS_W-1:0] CLS_RSVD6   = 3'd6;
    localparam logic [gdf_pkg::CLS_W-1:0] CLS_RSVD7   = 3'd7;
    localparam int GRID_CELLS = gdf_pkg::MAX_WIDTH_DEF * gdf_pkg::MAX_HEIGHT_DEF;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [gdf_pkg::DIST_W-1:0] distance;
        logic                       reachable;
        logic                       done_res;
    } t_cell_result;

    typedef struct {
        logic [gdf_pkg::OP_W-1:0]   op;
        logic [gdf_pkg::ADDR_W-1:0] addr;
        logic [gdf_pkg::CLS_W-1:0]  cls;
        bit                         fixed;
        logic [gdf_pkg::DIST_W-1:0] distance;
        logic                       reachable;
        logic                       done_res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [gdf_pkg::OP_W-1:0] i_opcode = '0;
    logic [gdf_pkg::ADDR_W-1:0] i_cell_addr = '0;
    logic [gdf_pkg::CLS_W-1:0] i_cell_class = '0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [gdf_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_reachable, o_done_res, o_cfg_ready;
    logic [gdf_pkg::DIST_W-1:0] o_distance;

    grid_dijkstra_distance_field_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // solver state
    logic [gdf_pkg::CLS_W-1:0]  class_mem [GRID_CELLS];
    logic [gdf_pkg::DIST_W-1:0] dist_mem [GRID_CELLS];
    bit                         reach_mem [GRID_CELLS];
    bit                         open_mem [GRID_CELLS];
    int                         reg_width = gdf_pkg::CFG_RST;
    int                         reg_height = gdf_pkg::CFG_RST;

    t_cell_result pending_q[$];
    int  fail_count = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic hold_req = 1'b0;
    int  hold_left = 0;

    function automatic int dim_in_use(int r, int m);
        if (r == 0) return 1;
        if (r > m) return m;
        return r;
    endfunction

    task automatic solve_field();
        int w, h, n, open_cnt, best, x, y, nx, ny, ni, nd;
        int bestd;
        bit found;
        int dxs [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
        int dys [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
        w = dim_in_use(reg_width, gdf_pkg::MAX_WIDTH_DEF);
        h = dim_in_use(reg_height, gdf_pkg::MAX_HEIGHT_DEF);
        n = w * h;
        open_cnt = 0;
        for (int i = 0; i < n; i++) begin
            dist_mem[i] = '0;
            open_mem[i] = 1'b0;
            reach_mem[i] = 1'b0;
            if (class_mem[i] == gdf_pkg::CLS_GOAL) begin
                reach_mem[i] = 1'b1;
                open_mem[i] = 1'b1;
                open_cnt++;
            end
        end
        while (open_cnt > 0) begin
            found = 1'b0;
            best = 0;
            bestd = 0;
            for (int i = 0; i < n; i++)
                if (open_mem[i] && (!found || int'(dist_mem[i]) < bestd)) begin
                    best = i;
                    bestd = dist_mem[i];
                    found = 1'b1;
                end
            open_mem[best] = 1'b0;
            open_cnt--;
            x = best % w;
            y = best / w;
            for (int d = 0; d < 8; d++) begin
                nx = x + dxs[d];
                ny = y + dys[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                ni = ny * w + nx;
                if (!gdf_pkg::enterable(class_mem[ni])) continue;
                nd = bestd + ((d < 4) ? int'(gdf_pkg::COST_ORTHO) : int'(gdf_pkg::COST_DIAG));
                if (class_mem[ni] == gdf_pkg::CLS_WATER) nd += int'(gdf_pkg::COST_WATER);
                if (nd > int'(gdf_pkg::DIST_MAX)) nd = int'(gdf_pkg::DIST_MAX);
                if (!reach_mem[ni] || nd < int'(dist_mem[ni])) begin
                    dist_mem[ni] = gdf_pkg::DIST_W'(nd);
                    reach_mem[ni] = 1'b1;
                    if (!open_mem[ni]) begin
                        open_mem[ni] = 1'b1;
                        open_cnt++;
                    end
                end
            end
        end
    endtask

    task automatic predict_cell(input logic [gdf_pkg::OP_W-1:0] op,
                                input logic [gdf_pkg::ADDR_W-1:0] a,
                                input logic [gdf_pkg::CLS_W-1:0] c, output t_cell_result r);
        int n;
        r = '{default: '0};
        n = dim_in_use(reg_width, gdf_pkg::MAX_WIDTH_DEF)
            * dim_in_use(reg_height, gdf_pkg::MAX_HEIGHT_DEF);
        case (op)
            gdf_pkg::OP_WRITE: begin
                class_mem[a] = c;
                r.done_res = 1'b1;
            end
            gdf_pkg::OP_COMPUTE: begin
                solve_field();
                r.done_res = 1'b1;
            end
            gdf_pkg::OP_READ: begin
                if (int'(a) < n && reach_mem[a]) begin
                    r.distance = dist_mem[a];
                    r.reachable = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_cell(input logic [gdf_pkg::OP_W-1:0] op,
                             input logic [gdf_pkg::ADDR_W-1:0] a,
                             input logic [gdf_pkg::CLS_W-1:0] c, input bit fixed = 1'b0,
                             input t_cell_result typed = '{default: '0});
        t_cell_result r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_cell_addr <= a;
        i_cell_class <= c;
        do @(posedge i_clk); while (o_stall);
        predict_cell(op, a, c, r);
        if (fixed) r = typed;
        pending_q.push_back(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [gdf_pkg::CFG_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == gdf_pkg::REG_WIDTH) reg_width = val;
        else reg_height = val;
        @(posedge i_clk);
    endtask

    function automatic logic [gdf_pkg::CLS_W-1:0] pick_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CLS_BLOCKED;
        if (r < 55) return gdf_pkg::CLS_ROAD;
        if (r < 75) return gdf_pkg::CLS_WATER;
        if (r < 87) return gdf_pkg::CLS_CHECK;
        if (r < 94) return gdf_pkg::CLS_GOAL;
        return 3'($urandom_range(5, 7));
    endfunction

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_cell_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result dist=%0d reach=%0b done=%0b",
                         $time, o_distance, o_reachable, o_done_res);
                fail_count++;
            end else begin
                e = pending_q.pop_front();
                if (o_distance !== e.distance || o_reachable !== e.reachable
                    || o_done_res !== e.done_res) begin
                    $display("%0t: mismatch expected dist=%0d reach=%0b done=%0b, %s",
                             $time, e.distance, e.reachable, e.done_res,
                             $sformatf("actual dist=%0d reach=%0b done=%0b",
                                       o_distance, o_reachable, o_done_res));
                    fail_count++;
                end
            end
        end
    end

    t_stim_row dir_tab [0:30] = '{
        '{gdf_pkg::OP_READ,    10'd0,    CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd1023, CLS_RSVD7,          1, 17'd0, 1'b0, 1'b0},
        '{OP_NONE,             10'd1023, CLS_RSVD7,          1, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_WRITE,   10'd0,    gdf_pkg::CLS_GOAL,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd1,    gdf_pkg::CLS_ROAD,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd2,    gdf_pkg::CLS_WATER, 1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd3,    gdf_pkg::CLS_CHECK, 1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd4,    CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd5,    CLS_RSVD7,          1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd6,    gdf_pkg::CLS_ROAD,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd7,    CLS_RSVD5,          1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd8,    gdf_pkg::CLS_ROAD,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd9,    gdf_pkg::CLS_WATER, 1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd10,   gdf_pkg::CLS_ROAD,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd11,   CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd12,   gdf_pkg::CLS_WATER, 1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd13,   gdf_pkg::CLS_ROAD,  1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd14,   gdf_pkg::CLS_CHECK, 1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_WRITE,   10'd15,   CLS_RSVD6,          1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_COMPUTE, 10'd0,    CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b1},
        '{gdf_pkg::OP_READ,    10'd0,    CLS_BLOCKED,        1, 17'd0, 1'b1, 1'b0},
        '{gdf_pkg::OP_READ,    10'd16,   CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd1023, CLS_BLOCKED,        1, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd1,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd2,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd3,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd4,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd5,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd9,    CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd12,   CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0},
        '{gdf_pkg::OP_READ,    10'd15,   CLS_BLOCKED,        0, 17'd0, 1'b0, 1'b0}
    };

    int phase_w [4] = '{63, 0, 3, 4};
    int phase_h [4] = '{1, 0, 3, 2};
    int idle_tx [4] = '{0, 58, 0, 30};
    int idle_rx [4] = '{0, 0, 58, 30};

    initial begin
        t_cell_result typed;
        int n;
        for (int i = 0; i < GRID_CELLS; i++) begin
            class_mem[i] = CLS_BLOCKED;
            dist_mem[i] = '0;
            reach_mem[i] = 1'b0;
            open_mem[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the directed map writes every cell of the 4 by 4 grid before its compute
        write_reg(gdf_pkg::REG_WIDTH, 6'd4);
        write_reg(gdf_pkg::REG_HEIGHT, 6'd4);
        foreach (dir_tab[k]) begin
            typed = '{dir_tab[k].distance, dir_tab[k].reachable, dir_tab[k].done_res};
            send_cell(dir_tab[k].op, dir_tab[k].addr, dir_tab[k].cls, dir_tab[k].fixed, typed);
        end

        foreach (phase_w[p]) begin
            write_reg(gdf_pkg::REG_WIDTH, 6'(phase_w[p]));
            write_reg(gdf_pkg::REG_HEIGHT, 6'(phase_h[p]));
            tx_idle_pct = idle_tx[p];
            rx_stall_pct = idle_rx[p];
            n = dim_in_use(reg_width, gdf_pkg::MAX_WIDTH_DEF)
                * dim_in_use(reg_height, gdf_pkg::MAX_HEIGHT_DEF);
            for (int i = 0; i < n; i++) send_cell(gdf_pkg::OP_WRITE, 10'(i), pick_class());
            if (p != 1) send_cell(gdf_pkg::OP_WRITE, 10'($urandom_range(0, n - 1)),
                                  gdf_pkg::CLS_GOAL);
            send_cell(gdf_pkg::OP_COMPUTE, 10'($urandom), 3'($urandom));
            if (p == 2) begin
                // long hold-off on the result side while items keep coming
                drain();
                @(posedge i_clk);
                hold_req <= 1'b1;
                tx_idle_pct = 0;
            end
            repeat (4) begin
                if ($urandom_range(0, 3) == 0)
                    send_cell(gdf_pkg::OP_READ, 10'($urandom_range(0, 1023)), 3'($urandom));
                else
                    send_cell(gdf_pkg::OP_READ, 10'($urandom_range(0, n - 1)), 3'($urandom));
            end
            tx_idle_pct = idle_tx[p];
            // noise: any opcode within the grid in use
            repeat (2) send_cell(2'($urandom), 10'($urandom_range(0, n - 1)), 3'($urandom));
            send_cell(gdf_pkg::OP_COMPUTE, 10'd0, CLS_BLOCKED);
            repeat (2) send_cell(gdf_pkg::OP_READ, 10'($urandom_range(0, n - 1)), CLS_BLOCKED);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
